// ===== rtl/radial_zoom_blur_macros.svh =====
// ---------------------------------------------------------------------------
// Radial zoom blur assertion macros
// Concurrent assertion helpers; define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef RADIAL_ZOOM_BLUR_MACROS_SVH
`define RADIAL_ZOOM_BLUR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define RZB_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RZB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define RZB_ASSERT(lbl, clk, rstn, ante, cons)
`define RZB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/rzb_pkg.sv =====
// ---------------------------------------------------------------------------
// Radial zoom blur package
// Field widths, register codes, opcodes and parameter defaults.
// ---------------------------------------------------------------------------
package rzb_pkg;

  // parameter defaults
  localparam int unsigned DEF_MAX_WIDTH     = 512;
  localparam int unsigned DEF_MAX_HEIGHT    = 512;
  localparam int unsigned DEF_FRACTION_BITS = 16;

  // word fields
  localparam int unsigned COORD_W = 9;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned LANE_W  = 8;
  localparam int unsigned LANES   = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned DIM_CFG_W   = 10;
  localparam int unsigned SHIFT_CFG_W = 3;
  localparam int unsigned STEP_W      = 13;

  localparam int unsigned DIM_MIN    = 2;
  localparam int unsigned DIM_RST    = 512;
  localparam int unsigned SHIFT_MIN  = 2;
  localparam int unsigned SHIFT_MAX  = 4;
  localparam int unsigned SHIFT_RST  = 4;
  localparam int unsigned STEP_LIMIT = 6553;
  localparam int unsigned STEP_RST   = 1966;

  // per-lane sum holds up to 2^SHIFT_MAX samples of LANE_W bits
  localparam int unsigned SUM_W = LANE_W + SHIFT_MAX;
  localparam int unsigned K_W   = SHIFT_MAX + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_LAYERS_SHIFT = 2'd2,
    CFG_SCALE_STEP   = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_RENDER = 1'b1
  } op_e;

endpackage

// ===== rtl/rzb_ifs.sv =====
// ---------------------------------------------------------------------------
// Radial zoom blur channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ---------------------------------------------------------------------------
interface rzb_in_if import rzb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [PIX_W-1:0]   pixel_value;

  modport source (output valid, opcode, pixel_x, pixel_y, pixel_value, input ready);
  modport sink   (input valid, opcode, pixel_x, pixel_y, pixel_value, output ready);
endinterface

interface rzb_out_if import rzb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   out_pixel;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;

  modport source (output valid, out_pixel, out_x, out_y, input ready);
  modport sink   (input valid, out_pixel, out_x, out_y, output ready);
endinterface

interface rzb_cfg_if import rzb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] reg_data;

  modport source (output valid, reg_index, reg_data, input ready);
  modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

// ===== rtl/rzb_ram.sv =====
// ---------------------------------------------------------------------------
// Radial zoom blur generic RAM
// Single-port memory: a read each cycle, a write on we_i, registered output.
// ---------------------------------------------------------------------------
module rzb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/radial_zoom_blur.sv =====
// A load word in range is written in the cycle it is accepted.
// A render word steps each sample through S_MULX (x product), S_MULY (y product,
// column clamp) and S_ADDR (row clamp, frame read), then S_DONE folds the last
// read and presents the result once the output register is free; no new word is
// taken until then. The result waits in an output register, so loads proceed.
// Reset: config returns to defaults, control clears; datapath, frame store not cleared.
// ---------------------------------------------------------------------------
// Radial zoom blur engine
// Frame store plus a sequencer that averages 2^layers_shift samples taken
// along the ray from the frame center through each rendered pixel.
// ---------------------------------------------------------------------------
`include "radial_zoom_blur_macros.svh"

module radial_zoom_blur import rzb_pkg::*; #(
  parameter int unsigned MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rzb_in_if.sink    in_i,
  rzb_out_if.source out_o,
  rzb_cfg_if.sink   cfg_i
);

  // -------------------------------------------------------------------------
  // Derived widths
  // -------------------------------------------------------------------------
  // frame size registers hold 2..MAX inclusive
  localparam int unsigned FW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned FH = $clog2(MAX_HEIGHT + 1);
  // store is addressed {row, column}
  localparam int unsigned COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned ADDR_W = COL_W + ROW_W;
  localparam int unsigned DEPTH  = 2 ** ADDR_W;
  // signed offset from center
  localparam int unsigned DIM_A  = (FW > FH) ? FW : FH;
  localparam int unsigned DIM_W  = (DIM_A > COORD_W) ? DIM_A : COORD_W;
  localparam int unsigned DX_W   = DIM_W + 1;
  // scale runs from 1.0 down to 1.0 - 15*step, which may go negative
  localparam int unsigned SC_W   = ((FRACTION_BITS > 17) ? FRACTION_BITS : 17) + 2;
  localparam int unsigned P_W    = DX_W + SC_W;
  // sample position before clamping
  localparam int unsigned C_W    = P_W - FRACTION_BITS + 1;

  localparam int unsigned W_RST = (DIM_RST > MAX_WIDTH) ? MAX_WIDTH : DIM_RST;
  localparam int unsigned H_RST = (DIM_RST > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RST;

  localparam logic signed [SC_W-1:0] SCALE_ONE = SC_W'(64'd1 << FRACTION_BITS);

  // one-hot sequencer
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MULX = 5'b00010,  // dx * scale
    S_MULY = 5'b00100,  // dy * scale, clamp column
    S_ADDR = 5'b01000,  // clamp row, read frame
    S_DONE = 5'b10000   // fold last sample, present result
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [FW-1:0]          fw_q, fw_d;
  logic [FH-1:0]          fh_q, fh_d;
  logic [SHIFT_CFG_W-1:0] shift_q, shift_d;
  logic [STEP_W-1:0]      step_q, step_d;

  // render context
  logic [COORD_W-1:0]     x_q, x_d, y_q, y_d;
  logic signed [DX_W-1:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [SC_W-1:0] scale_q, scale_d;
  logic signed [P_W-1:0]  prod_q, prod_d;
  logic [COL_W-1:0]       col_q, col_d;
  logic [K_W-1:0]         k_q, k_d;
  logic                   pend_q, pend_d;
  logic [SUM_W-1:0]       sum_q [LANES];
  logic [SUM_W-1:0]       sum_d [LANES];

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [PIX_W-1:0]       out_pixel_q, out_pixel_d;
  logic [COORD_W-1:0]     out_x_q, out_x_d, out_y_q, out_y_d;

  logic [FW-1:0]          cx;
  logic [FH-1:0]          cy;
  logic [K_W-1:0]         cnt;
  logic                   in_fire, cfg_fire, in_range;
  logic [PIX_W-1:0]       avg_pixel;

  // shared multiplier and clamp
  logic signed [DX_W-1:0] mul_a;
  logic signed [P_W-1:0]  mul_res;
  logic signed [C_W-1:0]  sx, ctr, lim, pos;
  logic [C_W-1:0]         clamp_res;

  // frame store port
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_addr;
  logic [PIX_W-1:0]       ram_rdata;

  logic [DIM_CFG_W-1:0]   cfg_dim;
  logic [SHIFT_CFG_W-1:0] cfg_shift;
  logic [STEP_W-1:0]      cfg_step;

  assign cx  = fw_q >> 1;
  assign cy  = fh_q >> 1;
  assign cnt = K_W'(1) << shift_q;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;
  assign in_range    = (32'(in_i.pixel_x) < MAX_WIDTH) && (32'(in_i.pixel_y) < MAX_HEIGHT);

  assign out_o.valid     = out_valid_q;
  assign out_o.out_pixel = out_pixel_q;
  assign out_o.out_x     = out_x_q;
  assign out_o.out_y     = out_y_q;

  // -------------------------------------------------------------------------
  // Shared multiplier: x offset in S_MULX, y offset otherwise
  // -------------------------------------------------------------------------
  assign mul_a   = (state_q == S_MULX) ? dx_q : dy_q;
  assign mul_res = mul_a * scale_q;

  // -------------------------------------------------------------------------
  // Shared clamp: column in S_MULY, row in S_ADDR.
  // Arithmetic shift gives floor division for negative products.
  // -------------------------------------------------------------------------
  always_comb begin
    sx = C_W'(prod_q >>> FRACTION_BITS);
    if (state_q == S_MULY) begin
      ctr = $signed(C_W'(cx));
      lim = $signed(C_W'(fw_q)) - $signed(C_W'(1));
    end else begin
      ctr = $signed(C_W'(cy));
      lim = $signed(C_W'(fh_q)) - $signed(C_W'(1));
    end
    pos = sx + ctr;
    if (pos < $signed(C_W'(0))) begin
      clamp_res = '0;
    end else if (pos > lim) begin
      clamp_res = lim;
    end else begin
      clamp_res = pos;
    end
  end

  // lane averages: sum over samples, then shift right by log2 of the sample count
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      avg_pixel[l*LANE_W +: LANE_W] = LANE_W'(sum_q[l] >> shift_q);
    end
  end

  // -------------------------------------------------------------------------
  // Register writes, saturated into range
  // -------------------------------------------------------------------------
  assign cfg_dim   = cfg_i.reg_data[DIM_CFG_W-1:0];
  assign cfg_shift = cfg_i.reg_data[SHIFT_CFG_W-1:0];
  assign cfg_step  = cfg_i.reg_data[STEP_W-1:0];

  always_comb begin
    fw_d    = fw_q;
    fh_d    = fh_q;
    shift_d = shift_q;
    step_d  = step_q;
    if (cfg_fire) begin
      unique case (cfg_reg_e'(cfg_i.reg_index))
        CFG_FRAME_WIDTH: begin
          if (32'(cfg_dim) < DIM_MIN) fw_d = FW'(DIM_MIN);
          else if (32'(cfg_dim) > MAX_WIDTH) fw_d = FW'(MAX_WIDTH);
          else fw_d = FW'(cfg_dim);
        end
        CFG_FRAME_HEIGHT: begin
          if (32'(cfg_dim) < DIM_MIN) fh_d = FH'(DIM_MIN);
          else if (32'(cfg_dim) > MAX_HEIGHT) fh_d = FH'(MAX_HEIGHT);
          else fh_d = FH'(cfg_dim);
        end
        CFG_LAYERS_SHIFT: begin
          if (32'(cfg_shift) < SHIFT_MIN) shift_d = SHIFT_CFG_W'(SHIFT_MIN);
          else if (32'(cfg_shift) > SHIFT_MAX) shift_d = SHIFT_CFG_W'(SHIFT_MAX);
          else shift_d = cfg_shift;
        end
        CFG_SCALE_STEP: begin
          if (32'(cfg_step) > STEP_LIMIT) step_d = STEP_W'(STEP_LIMIT);
          else step_d = cfg_step;
        end
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    scale_d     = scale_q;
    prod_d      = prod_q;
    col_d       = col_q;
    k_d         = k_q;
    pend_d      = 1'b0;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_pixel_d = out_pixel_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    ram_we      = 1'b0;
    ram_addr    = {ROW_W'(in_i.pixel_y), COL_W'(in_i.pixel_x)};

    // read data of the previous S_ADDR lands now
    if (pend_q) begin
      for (int l = 0; l < LANES; l++) begin
        sum_d[l] = sum_q[l] + SUM_W'(ram_rdata[l*LANE_W +: LANE_W]);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.opcode == OP_RENDER) begin
            x_d     = in_i.pixel_x;
            y_d     = in_i.pixel_y;
            dx_d    = $signed(DX_W'(in_i.pixel_x)) - $signed(DX_W'(cx));
            dy_d    = $signed(DX_W'(in_i.pixel_y)) - $signed(DX_W'(cy));
            scale_d = SCALE_ONE;
            k_d     = '0;
            for (int l = 0; l < LANES; l++) begin
              sum_d[l] = '0;
            end
            state_d = S_MULX;
          end else begin
            ram_we = in_range;
          end
        end
      end
      S_MULX: begin
        prod_d  = mul_res;
        state_d = S_MULY;
      end
      S_MULY: begin
        col_d   = clamp_res[COL_W-1:0];
        prod_d  = mul_res;
        state_d = S_ADDR;
      end
      S_ADDR: begin
        ram_addr = {clamp_res[ROW_W-1:0], col_q};
        pend_d   = 1'b1;
        scale_d  = scale_q - $signed(SC_W'(step_q));
        k_d      = k_q + K_W'(1);
        state_d  = (k_q + K_W'(1) == cnt) ? S_DONE : S_MULX;
      end
      S_DONE: begin
        // wait for the last sample and a free output register
        if (!pend_q && (!out_valid_q || out_o.ready)) begin
          out_valid_d = 1'b1;
          out_pixel_d = avg_pixel;
          out_x_d     = x_q;
          out_y_d     = y_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      fw_q        <= FW'(W_RST);
      fh_q        <= FH'(H_RST);
      shift_q     <= SHIFT_CFG_W'(SHIFT_RST);
      step_q      <= STEP_W'(STEP_RST);
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      fw_q        <= fw_d;
      fh_q        <= fh_d;
      shift_q     <= shift_d;
      step_q      <= step_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    y_q         <= y_d;
    dx_q        <= dx_d;
    dy_q        <= dy_d;
    scale_q     <= scale_d;
    prod_q      <= prod_d;
    col_q       <= col_d;
    sum_q       <= sum_d;
    out_pixel_q <= out_pixel_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
  end

  // -------------------------------------------------------------------------
  // Frame store
  // -------------------------------------------------------------------------
  rzb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_i.pixel_value),
    .rdata_o (ram_rdata)
  );

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `RZB_ASSERT_NEXT(a_render_starts, clk_i, rst_ni, in_fire && in_i.opcode == OP_RENDER, state_q == S_MULX)
  `RZB_ASSERT(a_sample_bound, clk_i, rst_ni, state_q == S_ADDR, k_q < cnt)
  `RZB_ASSERT(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == S_DONE)
  `RZB_ASSERT(a_pend_after_read, clk_i, rst_ni, pend_q, $past(state_q) == S_ADDR)

endmodule
